FILE: src/sqi_pkg.sv
`default_nettype none
package sqi_pkg;

  localparam int unsigned DATA_W = 32;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_POP    = 1'b1;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_EMPTY = 2'd1;
  localparam logic [1:0] ERR_FULL  = 2'd2;

  // broadcast to every cell; ins/pop already qualified by full/empty
  typedef struct packed {
    logic                     ins;
    logic                     pop;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage
`default_nettype wire

FILE: src/sorted_insert_queue.sv
`default_nettype none
// Sorted queue of signed 32-bit values, smallest at the head. Each beat on
// start (taken when busy is low) is an insert or a pop; its result appears
// on the next cycle with done high for exactly one cycle, and the receiver
// cannot stall it. busy stays low, so a new request can be issued every
// cycle: every cell compares the broadcast value and shifts to its
// neighbor in the same cycle. An insert into a full queue is dropped with
// error 2; a pop on an empty queue returns error 1. fill_count shows the
// low five bits of the count after the request.
module sorted_insert_queue #(
  parameter int CAPACITY = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                req_type,
  input  wire logic signed [sqi_pkg::DATA_W-1:0]   value,
  output logic                                     done,
  output logic signed [sqi_pkg::DATA_W-1:0]        pop_value,
  output logic                                     pop_valid,
  output logic [1:0]                               error_code,
  output logic [4:0]                               fill_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]                 count;
  logic [CNT_W-1:0]                 count_next;
  logic                             accept;
  logic                             is_full;
  logic                             is_empty;
  sqi_pkg::cell_cmd_t               cmd;
  logic signed [sqi_pkg::DATA_W-1:0] cell_data  [CAPACITY];
  logic                             cell_shift [CAPACITY];
  logic [1:0]                       err_next;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = count == CAP;
  assign is_empty = count == '0;

  assign cmd.ins   = accept && (req_type == sqi_pkg::REQ_INSERT) && !is_full;
  assign cmd.pop   = accept && (req_type == sqi_pkg::REQ_POP) && !is_empty;
  assign cmd.value = value;

  always_comb begin
    count_next = count;
    err_next   = sqi_pkg::ERR_OK;
    if (cmd.ins) begin
      count_next = count + 1'b1;
    end else if (cmd.pop) begin
      count_next = count - 1'b1;
    end else if (req_type == sqi_pkg::REQ_POP) begin
      err_next = sqi_pkg::ERR_EMPTY;
    end else begin
      err_next = sqi_pkg::ERR_FULL;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sqi_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count),
      .prev_data  (cell_data[(i == 0) ? 0 : i - 1]),
      .prev_shift ((i == 0) ? 1'b0 : cell_shift[(i == 0) ? 0 : i - 1]),
      .next_data  (cell_data[(i == CAPACITY - 1) ? i : i + 1]),
      .data       (cell_data[i]),
      .shift      (cell_shift[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pop_value  <= cmd.pop ? cell_data[0] : '0;
      pop_valid  <= cmd.pop;
      error_code <= err_next;
      fill_count <= 5'(count_next);
    end
  end

endmodule
`default_nettype wire

FILE: src/sqi_cell.sv
`default_nettype none
module sqi_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  wire logic                             clk,
  input  wire sqi_pkg::cell_cmd_t               cmd,
  input  wire logic [CNT_W-1:0]                 count,
  input  wire logic signed [sqi_pkg::DATA_W-1:0] prev_data,
  input  wire logic                             prev_shift,
  input  wire logic signed [sqi_pkg::DATA_W-1:0] next_data,
  output logic signed [sqi_pkg::DATA_W-1:0]      data,
  output logic                                  shift
);

  localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

  logic                             occupied;
  logic                             at_end;
  logic signed [sqi_pkg::DATA_W-1:0] data_next;

  assign occupied = IDX < count;
  assign at_end   = IDX == count;
  // entry is larger than the new value: it moves up one cell on insert
  assign shift    = occupied && (cmd.value < data);

  always_comb begin
    data_next = data;
    if (cmd.ins) begin
      if (prev_shift) begin
        data_next = prev_data;
      end else if (shift || at_end) begin
        data_next = cmd.value;
      end
    end else if (cmd.pop) begin
      data_next = next_data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule
`default_nettype wire

FILE: src/sqi_checker.sv
`default_nettype none
module sqi_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [31:0] pop_value,
  input wire logic        pop_valid,
  input wire logic [1:0]  error_code,
  input wire logic [4:0]  fill_count
);

  // every accepted beat answers on the next cycle
  a_answer: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done)
    else $error("accepted request gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result without a request");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    done && error_code != sqi_pkg::ERR_OK |-> !pop_valid && pop_value == '0)
    else $error("failed request carries a value");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    done && $past(done) && error_code == sqi_pkg::ERR_OK |->
      (pop_valid && fill_count == $past(fill_count) - 5'd1) ||
      (!pop_valid && fill_count == $past(fill_count) + 5'd1))
    else $error("fill count moved wrongly");

  a_fill_hold: assert property (@(posedge clk) disable iff (rst)
    done && $past(done) && error_code != sqi_pkg::ERR_OK |->
      fill_count == $past(fill_count))
    else $error("failed request changed the count");

endmodule

bind sorted_insert_queue sqi_checker u_sqi_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .pop_value  (pop_value),
  .pop_valid  (pop_valid),
  .error_code (error_code),
  .fill_count (fill_count)
);
`default_nettype wire

FILE: test/sorted_insert_queue_checker.sv
`timescale 1ns / 100ps
module sorted_insert_queue_checker #(
  parameter int CAPACITY = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic                              busy,
  input  wire logic                              req_type,
  input  wire logic signed [sqi_pkg::DATA_W-1:0] value,
  input  wire logic                              done,
  input  wire logic signed [sqi_pkg::DATA_W-1:0] pop_value,
  input  wire logic                              pop_valid,
  input  wire logic [1:0]                        error_code,
  input  wire logic [4:0]                        fill_count,
  output int                                     mismatches,
  output int                                     outstanding
);

  typedef struct packed {
    logic signed [sqi_pkg::DATA_W-1:0] pop_value;
    logic                              pop_valid;
    logic [1:0]                        error_code;
    logic [4:0]                        fill_count;
  } request_result_t;

  // ascending contents of the queue as the block should hold them
  logic signed [sqi_pkg::DATA_W-1:0] held_values[$];
  request_result_t                   awaited_results[$];
  int                                error_total = 0;

  function automatic request_result_t apply_request(
    input logic kind,
    input logic signed [sqi_pkg::DATA_W-1:0] val
  );
    request_result_t r;
    int pos;
    r = '0;
    r.error_code = sqi_pkg::ERR_OK;
    if (kind == sqi_pkg::REQ_POP) begin
      if (held_values.size() == 0) begin
        r.error_code = sqi_pkg::ERR_EMPTY;
      end else begin
        r.pop_value = held_values.pop_front();
        r.pop_valid = 1'b1;
      end
    end else if (held_values.size() >= CAPACITY) begin
      r.error_code = sqi_pkg::ERR_FULL;
    end else begin
      // new value goes after any equal entries
      pos = 0;
      while (pos < held_values.size() && !(val < held_values[pos]))
        pos++;
      held_values.insert(pos, val);
    end
    r.fill_count = 5'(held_values.size());
    return r;
  endfunction

  always @(posedge clk) begin : scoreboard
    request_result_t want;
    if (rst) begin
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      // push before pop so a result in the same cycle as its request would still line up
      if (start && !busy)
        awaited_results.push_back(apply_request(req_type, value));
      if (done) begin
        if (awaited_results.size() == 0) begin
          error_total++;
          if (error_total <= 10)
            $display({"%0t: unexpected result beat: pop_value=%0d pop_valid=%0b ",
                      "error_code=%0d fill_count=%0d"},
                     $time, pop_value, pop_valid, error_code, fill_count);
        end else begin
          want = awaited_results.pop_front();
          if (pop_value !== want.pop_value || pop_valid !== want.pop_valid ||
              error_code !== want.error_code || fill_count !== want.fill_count) begin
            error_total++;
            if (error_total <= 10)
              $display({"%0t: result mismatch: expected pop_value=%0d pop_valid=%0b ",
                        "error_code=%0d fill_count=%0d, got pop_value=%0d ",
                        "pop_valid=%0b error_code=%0d fill_count=%0d"},
                       $time, want.pop_value, want.pop_valid, want.error_code,
                       want.fill_count, pop_value, pop_valid, error_code, fill_count);
          end
        end
      end
      mismatches  <= error_total;
      outstanding <= awaited_results.size();
    end
  end

endmodule

FILE: test/sorted_insert_queue_tb.sv
`timescale 1ns / 100ps
module sorted_insert_queue_tb;

  localparam int CAPACITY    = 16;
  localparam int RANDOM_REQS = 700;
  localparam int STALL_LIMIT = 2000;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              start = 1'b0;
  logic                              req_type = sqi_pkg::REQ_INSERT;
  logic signed [sqi_pkg::DATA_W-1:0] value = '0;
  logic                              busy;
  logic                              done;
  logic signed [sqi_pkg::DATA_W-1:0] pop_value;
  logic                              pop_valid;
  logic [1:0]                        error_code;
  logic [4:0]                        fill_count;
  int                                mismatches;
  int                                outstanding;
  int                                stall_cycles = 0;

  sorted_insert_queue #(.CAPACITY(CAPACITY)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .value(value), .done(done), .pop_value(pop_value), .pop_valid(pop_valid),
    .error_code(error_code), .fill_count(fill_count)
  );

  sorted_insert_queue_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .value(value), .done(done), .pop_value(pop_value), .pop_valid(pop_valid),
    .error_code(error_code), .fill_count(fill_count),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog: any cycle with a request or result beat restarts the count
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // leaves start high; returns in the step of the accepting edge
  task automatic send_request(input logic kind,
                              input logic signed [sqi_pkg::DATA_W-1:0] val);
    start    <= 1'b1;
    req_type <= kind;
    value    <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // cycles must be nonzero
  task automatic hold_off(input int cycles);
    start    <= 1'b0;
    req_type <= 1'($urandom);
    value    <= $urandom;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic signed [sqi_pkg::DATA_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return $urandom;
    // narrow band so equal values collide often
    if (sel < 70) return 32'($urandom_range(0, 15)) - 32'd8;
    if (sel < 85) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh7fffffff;
        1:       return 32'sh80000000;
        2:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    if ($urandom_range(0, 1) == 0) return 32'sh80000000 + 32'($urandom_range(0, 7));
    return 32'sh7fffffff - 32'($urandom_range(0, 7));
  endfunction

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin : stimulus
    traffic_mix_t mix;
    int sent;
    int phase;
    int run_len;
    int pop_pct;
    int gap;
    bit burst;
    logic kind;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // directed: empty pop, extremes, duplicates, sign-boundary ordering
    send_request(sqi_pkg::REQ_POP, 32'sd0);
    send_request(sqi_pkg::REQ_INSERT, 32'sh7fffffff);
    send_request(sqi_pkg::REQ_INSERT, 32'sh80000000);
    send_request(sqi_pkg::REQ_INSERT, 32'sd0);
    send_request(sqi_pkg::REQ_INSERT, -32'sd1);
    hold_off(3);
    send_request(sqi_pkg::REQ_INSERT, 32'sd1);
    send_request(sqi_pkg::REQ_INSERT, 32'sh80000000);
    send_request(sqi_pkg::REQ_INSERT, 32'sh7fffffff);
    send_request(sqi_pkg::REQ_INSERT, 32'sh55555555);
    send_request(sqi_pkg::REQ_INSERT, 32'shaaaaaaaa);
    send_request(sqi_pkg::REQ_POP, 32'shffffffff);
    send_request(sqi_pkg::REQ_POP, 32'sh12345678);
    hold_off(1);
    send_request(sqi_pkg::REQ_INSERT, 32'sd5);
    send_request(sqi_pkg::REQ_INSERT, 32'sd5);
    repeat (8) send_request(sqi_pkg::REQ_POP, $urandom);
    send_request(sqi_pkg::REQ_POP, 32'sd0);
    wait_until_drained();

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_REQS) begin
      mix     = traffic_mix_t'($urandom_range(0, 2));
      run_len = $urandom_range(20, 80);
      burst   = ($urandom_range(0, 3) == 0);
      case (mix)
        MIX_FILL:  pop_pct = 20;
        MIX_DRAIN: pop_pct = 80;
        default:   pop_pct = 50;
      endcase
      repeat (run_len) begin
        kind = ($urandom_range(0, 99) < pop_pct) ? sqi_pkg::REQ_POP : sqi_pkg::REQ_INSERT;
        send_request(kind, pick_value());
        sent++;
        if (!burst) begin
          gap = pick_gap();
          if (gap > 0) hold_off(gap);
        end
      end
      if (phase == 0 || $urandom_range(0, 2) == 0)
        wait_until_drained();
      phase++;
    end

    wait_until_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
